>>> src/scrambled_halton_sampler_macros.svh
// assertion macros for the scrambled halton sampler
`ifndef SCRAMBLED_HALTON_SAMPLER_MACROS_SVH
`define SCRAMBLED_HALTON_SAMPLER_MACROS_SVH

`define SHS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SHS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/shs_pkg.sv
// types and constants for the scrambled halton sampler
package shs_pkg;

    localparam int MAX_DIMS = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BEGIN_HASH,
        ST_NEXT_HASH,
        ST_DIGITS,
        ST_CHECK,
        ST_FRACTION,
        ST_EXHAUSTED,
        ST_OUTPUT
    } shs_state_t;

    typedef struct packed {
        logic load_input;
        logic hash_start;
        logic hash_begin;
        logic digit_start;
        logic digit_step;
        logic frac_start;
        logic frac_step;
        logic finish_value;
        logic finish_exhausted;
    } shs_cmd_t;

    typedef struct packed {
        logic hash_done;
        logic digits_done;
        logic overflow;
        logic frac_done;
        logic exhausted;
        logic operation;
    } shs_status_t;

    function automatic logic [5:0] prime_of(input logic [3:0] d);
        logic [5:0] p;
        begin
            case (d)
                4'd0: p = 6'd2;
                4'd1: p = 6'd3;
                4'd2: p = 6'd5;
                4'd3: p = 6'd7;
                4'd4: p = 6'd11;
                4'd5: p = 6'd13;
                4'd6: p = 6'd17;
                4'd7: p = 6'd19;
                4'd8: p = 6'd23;
                4'd9: p = 6'd29;
                4'd10: p = 6'd31;
                4'd11: p = 6'd37;
                4'd12: p = 6'd41;
                4'd13: p = 6'd43;
                4'd14: p = 6'd47;
                default: p = 6'd53;
            endcase
            return p;
        end
    endfunction

endpackage

>>> src/shs_ctrl.sv
// controller state machine of the scrambled halton sampler
module shs_ctrl
    import shs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  shs_status_t status,
    output shs_cmd_t    cmd
);

    shs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_input = 1'b1;
                    state_next = ST_BEGIN_HASH;
                end
            end
            ST_BEGIN_HASH: begin
                if (!status.operation) begin
                    cmd.hash_start = 1'b1;
                    cmd.hash_begin = 1'b1;
                    state_next = ST_NEXT_HASH;
                end else if (status.exhausted) begin
                    cmd.finish_exhausted = 1'b1;
                    state_next = ST_OUTPUT;
                end else begin
                    cmd.hash_start = 1'b1;
                    state_next = ST_NEXT_HASH;
                end
            end
            ST_NEXT_HASH: begin
                if (status.hash_done) begin
                    if (!status.operation) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.digit_start = 1'b1;
                        state_next = ST_DIGITS;
                    end
                end
            end
            ST_DIGITS: begin
                if (status.digits_done) begin
                    state_next = ST_CHECK;
                end else begin
                    cmd.digit_step = 1'b1;
                end
            end
            ST_CHECK: begin
                if (status.overflow) begin
                    cmd.finish_value = 1'b1;
                    state_next = ST_OUTPUT;
                end else begin
                    cmd.frac_start = 1'b1;
                    state_next = ST_FRACTION;
                end
            end
            ST_FRACTION: begin
                if (status.frac_done) begin
                    cmd.finish_value = 1'b1;
                    state_next = ST_OUTPUT;
                end else begin
                    cmd.frac_step = 1'b1;
                end
            end
            ST_EXHAUSTED: begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> src/shs_datapath.sv
// hash, digit and fraction datapath of the scrambled halton sampler
module shs_datapath
    import shs_pkg::*;
#(
    parameter int NUM_DIMENSIONS = 16,
    parameter int FRACTION_BITS  = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  shs_cmd_t                 cmd,
    output shs_status_t              status,
    input  logic                     in_operation,
    input  logic [15:0]              in_pixel_x,
    input  logic [15:0]              in_pixel_y,
    input  logic [30:0]              in_sample_index,
    output logic [FRACTION_BITS-1:0] sample_value,
    output logic                     exhausted,
    output logic [4:0]               dimension
);

    localparam logic [4:0] NUM_DIMS_W = 5'(NUM_DIMENSIONS);

    logic        op_reg;
    logic [15:0] px_reg, py_reg;
    logic [30:0] index_reg;
    logic [31:0] scramble_reg;
    logic [4:0]  dim_reg;

    // hash sequencer: one multiply per step
    logic [2:0]  hstep_reg;
    logic        hbusy_reg, hdone_reg, hbegin_reg;
    logic [31:0] hv_reg, hacc_reg;
    logic [31:0] hmul_a, hmul_b, hmul_p;

    // digit loop: each digit first registers quotients by reciprocal multiply, then takes remainders
    logic [31:0] idx_reg, seed_reg;
    logic [31:0] idx_q_reg, seed_q_reg;
    logic        dphase_reg;
    logic [63:0] rev_reg, den_reg;
    logic [5:0]  base;
    logic [32:0] magic;
    logic [5:0]  shamt;
    logic [32:0] magic_tab [16];
    logic [5:0]  shamt_tab [16];
    logic [64:0] idx_prod, seed_prod;
    logic [31:0] idx_q, seed_q;
    logic [5:0]  idx_r, seed_r;

    // fraction loop
    logic [63:0] rem_reg;
    logic [FRACTION_BITS-1:0] q_reg;
    logic [5:0]  fcnt_reg;
    logic [64:0] rem_sh;

    logic [FRACTION_BITS-1:0] value_reg;
    logic        exh_reg;
    logic [4:0]  out_dim_reg;

    // ceil(2^(32+l) / p) with l = clog2(p) gives the exact quotient of any 32-bit word
    for (genvar gi = 0; gi < 16; gi++) begin : g_recip
        localparam longint P = longint'(prime_of(4'(gi)));
        localparam int L = $clog2(P);
        localparam longint M = ((longint'(1) << (32 + L)) + P - 1) / P;
        assign magic_tab[gi] = 33'(M);
        assign shamt_tab[gi] = 6'(32 + L);
    end

    assign base = prime_of(dim_reg[3:0]);
    assign magic = magic_tab[dim_reg[3:0]];
    assign shamt = shamt_tab[dim_reg[3:0]];
    assign idx_prod = 65'(idx_reg) * 65'(magic);
    assign seed_prod = 65'(seed_reg) * 65'(magic);
    assign idx_q = 32'(idx_prod >> shamt);
    assign seed_q = 32'(seed_prod >> shamt);
    assign idx_r = 6'(idx_reg - idx_q_reg * 32'(base));
    assign seed_r = 6'(seed_reg - seed_q_reg * 32'(base));
    assign rem_sh = {rem_reg, 1'b0};

    always_comb begin
        hmul_a = hv_reg;
        hmul_b = 32'h7feb352d;
        case (hstep_reg)
            3'd0: begin
                hmul_a = hbegin_reg ? {16'd0, px_reg} : {1'b0, index_reg};
                hmul_b = 32'd73856093;
            end
            3'd1: begin
                hmul_a = hbegin_reg ? {16'd0, py_reg} : {27'd0, dim_reg & 5'd15};
                hmul_b = 32'd19349663;
            end
            3'd2: begin
                hmul_a = hbegin_reg ? 32'd0 : scramble_reg;
                hmul_b = 32'd83492791;
            end
            3'd3: begin
                hmul_a = hacc_reg ^ (hacc_reg >> 16);
                hmul_b = 32'h7feb352d;
            end
            default: begin
                hmul_a = hv_reg ^ (hv_reg >> 15);
                hmul_b = 32'h846ca68b;
            end
        endcase
        hmul_p = hmul_a * hmul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= '0;
            scramble_reg <= '0;
            dim_reg <= '0;
            hbusy_reg <= 1'b0;
            hdone_reg <= 1'b0;
            hstep_reg <= '0;
            fcnt_reg <= '0;
            dphase_reg <= 1'b0;
        end else begin
            hdone_reg <= 1'b0;
            if (cmd.load_input) begin
                op_reg <= in_operation;
                px_reg <= in_pixel_x;
                py_reg <= in_pixel_y;
                if (!in_operation) begin
                    index_reg <= in_sample_index;
                end
            end
            if (cmd.hash_start) begin
                hbusy_reg <= 1'b1;
                hbegin_reg <= cmd.hash_begin;
                hstep_reg <= '0;
                hacc_reg <= '0;
            end else if (hbusy_reg) begin
                hstep_reg <= hstep_reg + 3'd1;
                if (hstep_reg < 3'd3) begin
                    hacc_reg <= hacc_reg ^ hmul_p;
                end else if (hstep_reg == 3'd3) begin
                    hv_reg <= hmul_p;
                end else begin
                    hv_reg <= hmul_p ^ (hmul_p >> 16);
                    hbusy_reg <= 1'b0;
                    hdone_reg <= 1'b1;
                    if (hbegin_reg) begin
                        scramble_reg <= hmul_p ^ (hmul_p >> 16);
                        dim_reg <= '0;
                    end
                end
            end
            if (cmd.digit_start) begin
                idx_reg <= {1'b0, index_reg} + 32'd1;
                seed_reg <= hv_reg;
                rev_reg <= '0;
                den_reg <= 64'd1;
                dphase_reg <= 1'b0;
            end else if (cmd.digit_step) begin
                if (!dphase_reg) begin
                    idx_q_reg <= idx_q;
                    seed_q_reg <= seed_q;
                    dphase_reg <= 1'b1;
                end else begin
                    idx_reg <= idx_q_reg;
                    seed_reg <= seed_q_reg;
                    rev_reg <= rev_reg * 64'(base) + 64'(idx_r ^ seed_r);
                    den_reg <= den_reg * 64'(base);
                    dphase_reg <= 1'b0;
                end
            end
            if (cmd.frac_start) begin
                rem_reg <= rev_reg;
                q_reg <= '0;
                fcnt_reg <= '0;
            end else if (cmd.frac_step) begin
                fcnt_reg <= fcnt_reg + 6'd1;
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_reg <= 64'(rem_sh - {1'b0, den_reg});
                    q_reg <= {q_reg[FRACTION_BITS-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[63:0];
                    q_reg <= {q_reg[FRACTION_BITS-2:0], 1'b0};
                end
            end
            if (cmd.finish_value) begin
                value_reg <= (rev_reg >= den_reg) ? '1 : q_reg;
                exh_reg <= 1'b0;
                out_dim_reg <= dim_reg & 5'd15;
                dim_reg <= dim_reg + 5'd1;
            end
            if (cmd.finish_exhausted) begin
                value_reg <= '0;
                exh_reg <= 1'b1;
                out_dim_reg <= NUM_DIMS_W;
            end
        end
    end

    assign status.hash_done = hdone_reg;
    assign status.digits_done = (idx_reg == 32'd0);
    assign status.overflow = (rev_reg >= den_reg);
    assign status.frac_done = (fcnt_reg == 6'(FRACTION_BITS));
    assign status.exhausted = (dim_reg >= NUM_DIMS_W);
    assign status.operation = op_reg;

    assign sample_value = value_reg;
    assign exhausted = exh_reg;
    assign dimension = out_dim_reg;

endmodule

>>> src/scrambled_halton_sampler.sv
// top level of the scrambled halton sampler
// usage:
// s_ channel takes one word per command; tuser is the operation
// (0 begins a pixel sample, 1 asks for the next dimension value)
// s_tdata packs pixel_x, pixel_y, sample_index from the lowest bit up
// a begin word gives no result; each next word gives one m_ word
// m_tdata packs sample_value, exhausted, dimension from the lowest bit up
// a next word runs the hash steps (one multiply each), then the digit loop over each
// base digit of index+1 (up to 32 digits), each a quotient step and a remainder step,
// then FRACTION_BITS steps of bit-serial restoring division; a saturating value skips
// the division and is sent as all ones
// one word is processed at a time; s_tready is high only when idle
// a begin word holds s_tready low until hashed; an exhausted next word skips the hash
// reset clears index, scramble and dimension counter
// if m_tready is low the result is held and no new word is accepted
// after NUM_DIMENSIONS values the result has exhausted set and value zero
module scrambled_halton_sampler
    import shs_pkg::*;
#(
    parameter int NUM_DIMENSIONS = 16,
    parameter int FRACTION_BITS  = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // pixel_x, pixel_y, sample_index, pad
    input  logic        s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((FRACTION_BITS+6+7)/8)*8-1:0] m_tdata // sample_value, exhausted, dimension
);

    `include "scrambled_halton_sampler_macros.svh"

    localparam int OUT_W = ((FRACTION_BITS + 6 + 7) / 8) * 8;

    shs_cmd_t    cmd;
    shs_status_t status;
    logic [FRACTION_BITS-1:0] value;
    logic        exh;
    logic [4:0]  dim;

    shs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    shs_datapath #(
        .NUM_DIMENSIONS (NUM_DIMENSIONS),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_operation    (s_tuser),
        .in_pixel_x      (s_tdata[15:0]),
        .in_pixel_y      (s_tdata[31:16]),
        .in_sample_index (s_tdata[62:32]),
        .sample_value    (value),
        .exhausted       (exh),
        .dimension       (dim)
    );

    assign m_tdata = OUT_W'({dim, exh, value});

    `SHS_ASSERT_IMPL(a_no_overlap, aclk, aresetn, s_tready, !m_tvalid)
    `SHS_ASSERT_IMPL(a_exh_value, aclk, aresetn, m_tvalid && exh, value == '0)
    `SHS_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule
